/* rtl/hsv_to_rgb_converter_assert.svh */
// Assertion macros for the HSV to RGB converter checker.
// Depends on a clock named clk and an active-high reset named rst in the using scope.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HSV_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hsv2rgb_pkg.sv */
// Shared constants and arithmetic helpers for the HSV to RGB converter.
// No dependencies.
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned CHAN_W = 8;

  typedef logic [CHAN_W-1:0] chan_t;

  // Conversion mode codes.
  localparam logic MODE_GENERIC = 1'b0;
  localparam logic MODE_RAINBOW = 1'b1;

  localparam chan_t FULL_LEVEL   = 8'd255;
  localparam chan_t REGION_WIDTH = 8'd43;
  localparam chan_t GREEN_SCALE  = 8'd185;
  localparam chan_t ONE_THIRD    = 8'(256 / 3);
  localparam chan_t TWO_THIRDS   = 8'((256 * 2) / 3);
  localparam chan_t RB_171       = 8'd171;
  localparam chan_t RB_170       = 8'd170;
  localparam logic [4:0] SECTION_MASK = 5'h1F;

  // Product of two levels, keeping the upper byte.
  function automatic chan_t mul8(input chan_t a, input chan_t b);
    logic [2*CHAN_W-1:0] prod;
    prod = a * b;
    return prod[2*CHAN_W-1:CHAN_W];
  endfunction

  // Scaling that never takes a nonzero level down to zero.
  function automatic chan_t video(input chan_t c, input chan_t s);
    chan_t scaled;
    scaled = mul8(c, s) + 8'd1;
    return (c == '0) ? '0 : scaled;
  endfunction

  // Hue region of width 43; the last region runs up to the top of the circle.
  function automatic logic [2:0] region_of(input chan_t h);
    logic [2:0] r;
    if (h >= 8'd215)      r = 3'd5;
    else if (h >= 8'd172) r = 3'd4;
    else if (h >= 8'd129) r = 3'd3;
    else if (h >= 8'd86)  r = 3'd2;
    else if (h >= 8'd43)  r = 3'd1;
    else                  r = 3'd0;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/hsv_to_rgb_converter.sv */
// HSV to RGB converter, top level: five-stage pipeline with a mode register.
// Depends on hsv2rgb_pkg.
`default_nettype none

//  Channel  | Signals                                     | Handshake
//  ---------+---------------------------------------------+-------------------------------
//  input    | start, hue_angle, saturation, brightness    | taken when start && !busy
//  result   | done, red_level, green_level, blue_level    | one-cycle strobe, no back-pressure
//  config   | cfg_valid, cfg_ready, cfg_data              | written when cfg_valid && cfg_ready
//
// A word may enter in any cycle in which busy is low, so the sustained rate is one word per
// clock. The rainbow path has four dependent products (section offset, green scale,
// saturation scaling, brightness scaling), at most one a stage. Reset clears the valid bits
// and selects the generic mode; busy is set by reset and cleared by the first clock edge
// out of it. The receiver cannot stall, so the pipeline never holds and busy stays low in
// operation. The mode is sampled with each input word and travels with it.

module hsv_to_rgb_converter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [hsv2rgb_pkg::CHAN_W-1:0] hue_angle,
  input  wire logic [hsv2rgb_pkg::CHAN_W-1:0] saturation,
  input  wire logic [hsv2rgb_pkg::CHAN_W-1:0] brightness,
  output logic                               done,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]     red_level,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]     green_level,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]     blue_level,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_data
);

  import hsv2rgb_pkg::*;

  logic conversion_mode;
  logic accept;

  // Stage 1: hue decomposition for both methods.
  logic       vld1, mode1;
  chan_t      sat1, bri1, rem1, third1, two1;
  logic [2:0] region1, sect1;

  // Stage 2: first products and rainbow section levels.
  logic       vld2, mode2;
  chan_t      sat2, bri2, sr2, st2, p2, rr2, rg2, rb2, floor2, vsq2;
  logic [2:0] region2;

  // Stage 3: generic result complete, rainbow green scaled.
  logic  vld3, mode3;
  chan_t sat3, bri3, floor3, vsq3, red3, grn3, blu3;

  // Stage 4: rainbow saturation applied.
  logic  vld4, mode4;
  chan_t bri4, vsq4, red4, grn4, blu4;

  // Combinational values between stages.
  logic [2:0] region0;
  chan_t      reg_base0, rem_base0, rem0, off8_0;
  chan_t      sr1c, st1c, p1c, rr1c, rg1c, rb1c, floor1c, vsq1c;
  chan_t      q2c, t2c, gr2c, gg2c, gb2c, grn_scaled2c;
  chan_t      red3c, grn3c, blu3c, red4c, grn4c, blu4c;

  // busy covers reset and the cycle straight after it; cfg writes are held off in that gap too.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      conversion_mode <= MODE_GENERIC;
    end else if (cfg_valid && cfg_ready) begin
      conversion_mode <= cfg_data;
    end
  end

  // Stage 0 logic: the region search is a short compare chain, and the remainder within
  // the region is scaled by six to span the full byte.
  always_comb begin
    region0   = region_of(hue_angle);
    reg_base0 = 8'(region0 * REGION_WIDTH);
    rem_base0 = hue_angle - reg_base0;
    rem0      = 8'(rem_base0 * 8'd6);
    off8_0    = {hue_angle[4:0] & SECTION_MASK, 3'b000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    mode1   <= conversion_mode;
    sat1    <= saturation;
    bri1    <= brightness;
    region1 <= region0;
    rem1    <= rem0;
    sect1   <= hue_angle[7:5];
    third1  <= mul8(off8_0, ONE_THIRD);
    two1    <= mul8(off8_0, TWO_THIRDS);
  end

  // Stage 1 logic: generic p and the partial products for q and t; rainbow section
  // colour, desaturation floor and squared brightness. Section adds wrap at a byte.
  always_comb begin
    sr1c    = mul8(sat1, rem1);
    st1c    = mul8(sat1, FULL_LEVEL - rem1);
    p1c     = mul8(bri1, FULL_LEVEL - sat1);
    floor1c = mul8(FULL_LEVEL - sat1, FULL_LEVEL - sat1);
    vsq1c   = mul8(bri1, bri1);
    case (sect1)
      3'd0: begin
        rr1c = FULL_LEVEL - third1; rg1c = third1;                 rb1c = '0;
      end
      3'd1: begin
        rr1c = RB_171;              rg1c = ONE_THIRD + third1;     rb1c = '0;
      end
      3'd2: begin
        rr1c = RB_171 - two1;       rg1c = RB_170 + third1;        rb1c = '0;
      end
      3'd3: begin
        rr1c = '0;                  rg1c = FULL_LEVEL - third1;    rb1c = third1;
      end
      3'd4: begin
        rr1c = '0;                  rg1c = RB_171 - two1;          rb1c = ONE_THIRD + two1;
      end
      3'd5: begin
        rr1c = third1;              rg1c = '0;                     rb1c = FULL_LEVEL - third1;
      end
      3'd6: begin
        rr1c = ONE_THIRD + third1;  rg1c = '0;                     rb1c = RB_171 - third1;
      end
      default: begin
        rr1c = RB_170 + third1;     rg1c = '0;                     rb1c = ONE_THIRD - third1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    mode2   <= mode1;
    sat2    <= sat1;
    bri2    <= bri1;
    region2 <= region1;
    sr2     <= sr1c;
    st2     <= st1c;
    p2      <= p1c;
    rr2     <= rr1c;
    rg2     <= rg1c;
    rb2     <= rb1c;
    floor2  <= floor1c;
    vsq2    <= vsq1c;
  end

  // Stage 2 logic: generic q and t and the region permutation, with grey passed
  // straight through when there is no saturation; rainbow green is scaled down.
  always_comb begin
    q2c          = mul8(bri2, FULL_LEVEL - sr2);
    t2c          = mul8(bri2, FULL_LEVEL - st2);
    grn_scaled2c = mul8(rg2, GREEN_SCALE);
    case (region2)
      3'd0:    begin gr2c = bri2; gg2c = t2c;  gb2c = p2;   end
      3'd1:    begin gr2c = q2c;  gg2c = bri2; gb2c = p2;   end
      3'd2:    begin gr2c = p2;   gg2c = bri2; gb2c = t2c;  end
      3'd3:    begin gr2c = p2;   gg2c = q2c;  gb2c = bri2; end
      3'd4:    begin gr2c = t2c;  gg2c = p2;   gb2c = bri2; end
      default: begin gr2c = bri2; gg2c = p2;   gb2c = q2c;  end
    endcase
    if (sat2 == '0) begin
      gr2c = bri2;
      gg2c = bri2;
      gb2c = bri2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    mode3  <= mode2;
    sat3   <= sat2;
    bri3   <= bri2;
    floor3 <= floor2;
    vsq3   <= vsq2;
    if (mode2 == MODE_RAINBOW) begin
      red3 <= rr2;
      grn3 <= grn_scaled2c;
      blu3 <= rb2;
    end else begin
      red3 <= gr2c;
      grn3 <= gg2c;
      blu3 <= gb2c;
    end
  end

  // Stage 3 logic: rainbow saturation. No saturation gives white; partial saturation
  // scales each level and adds the floor, wrapping at a byte.
  always_comb begin
    red3c = red3;
    grn3c = grn3;
    blu3c = blu3;
    if ((mode3 == MODE_RAINBOW) && (sat3 != FULL_LEVEL)) begin
      if (sat3 == '0) begin
        red3c = FULL_LEVEL;
        grn3c = FULL_LEVEL;
        blu3c = FULL_LEVEL;
      end else begin
        red3c = video(red3, sat3) + floor3;
        grn3c = video(grn3, sat3) + floor3;
        blu3c = video(blu3, sat3) + floor3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else begin
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    mode4 <= mode3;
    bri4  <= bri3;
    vsq4  <= vsq3;
    red4  <= red3c;
    grn4  <= grn3c;
    blu4  <= blu3c;
  end

  // Stage 4 logic: rainbow brightness by the squared level; a square that rounds to zero
  // gives black.
  always_comb begin
    red4c = red4;
    grn4c = grn4;
    blu4c = blu4;
    if ((mode4 == MODE_RAINBOW) && (bri4 != FULL_LEVEL)) begin
      if (vsq4 == '0) begin
        red4c = '0;
        grn4c = '0;
        blu4c = '0;
      end else begin
        red4c = video(red4, vsq4);
        grn4c = video(grn4, vsq4);
        blu4c = video(blu4, vsq4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    red_level   <= red4c;
    green_level <= grn4c;
    blue_level  <= blu4c;
  end

endmodule

`default_nettype wire

/* rtl/hsv2rgb_checker.sv */
// Port-level checker for the HSV to RGB converter, with its bind statement.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter_assert.svh.
`default_nettype none

`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [hsv2rgb_pkg::CHAN_W-1:0] saturation,
  input wire logic [hsv2rgb_pkg::CHAN_W-1:0] brightness,
  input wire logic                          done,
  input wire logic [hsv2rgb_pkg::CHAN_W-1:0] red_level,
  input wire logic [hsv2rgb_pkg::CHAN_W-1:0] green_level,
  input wire logic [hsv2rgb_pkg::CHAN_W-1:0] blue_level
);

  import hsv2rgb_pkg::*;

  logic accepted;
  logic is_black, is_white;
  logic dark_in, grey_full_in;

  assign accepted = start && !busy;
  assign is_black = (red_level == '0) && (green_level == '0) && (blue_level == '0);
  assign is_white = (red_level == FULL_LEVEL) && (green_level == FULL_LEVEL)
                    && (blue_level == FULL_LEVEL);
  assign dark_in      = accepted && (brightness == '0);
  assign grey_full_in = accepted && (saturation == '0) && (brightness == FULL_LEVEL);

  // Every accepted word is followed by its done strobe.
  `HSV_ASSERT_IMPL(a_latency, accepted, ##5 done, "accepted word produced no result")

  // No result without an earlier accepted word.
  `HSV_ASSERT_IMPL(a_no_spurious, done, $past(accepted, 5), "result without an input word")

  // Zero brightness is black in either mode.
  `HSV_ASSERT_IMPL(a_black, dark_in, ##5 (done && is_black), "zero brightness not black")

  // Unsaturated full brightness is white in either mode.
  `HSV_ASSERT_IMPL(a_white, grey_full_in, ##5 (done && is_white), "grey not white")

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);

`default_nettype wire

/* tb/tb_hsv_to_rgb_converter.sv */
// Self-checking testbench for hsv_to_rgb_converter: pixel words go in on the start/busy port,
// each colour is predicted in the active conversion mode and compared with every done strobe.
// Depends on hsv2rgb_pkg and the converter RTL, nothing else.

module tb_hsv_to_rgb_converter;
  import hsv2rgb_pkg::*;

  // Roughly how many random pixel words to send, split evenly over the random phases.
  localparam int unsigned RANDOM_WORDS  = 800;
  localparam int unsigned RANDOM_PHASES = 8;
  // The converter is a five-stage pipeline.
  localparam int unsigned PIPE_LATENCY  = 5;
  localparam int unsigned DRAIN_LIMIT   = 1000;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } colour_t;

  // Every input of the converter holds a known value from time zero.
  logic  clk         = 1'b0;
  logic  rst         = 1'b1;
  logic  start       = 1'b0;
  chan_t hue_angle   = '0;
  chan_t saturation  = '0;
  chan_t brightness  = '0;
  logic  cfg_valid   = 1'b0;
  logic  cfg_data    = MODE_GENERIC;

  logic  busy;
  logic  done;
  logic  cfg_ready;
  chan_t red_level;
  chan_t green_level;
  chan_t blue_level;

  // The testbench's own copy of the mode register, updated when a write is accepted.
  logic        active_mode = MODE_GENERIC;
  // Colours still to come out of the pipeline, oldest first.
  colour_t     pending_colours[$];
  colour_t     oldest_colour;
  int unsigned mismatches  = 0;
  // Longest idle stretch the sender may insert before a word; zero gives back-to-back words.
  int unsigned max_gap     = 4;
  int unsigned cycle_count = 0;

  hsv_to_rgb_converter dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .hue_angle   (hue_angle),
    .saturation  (saturation),
    .brightness  (brightness),
    .done        (done),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Colour prediction
  // ---------------------------------------------------------------------------------------

  // Upper byte of the product of two levels.
  function automatic int unsigned upper_byte(input int unsigned a, input int unsigned b);
    return ((a & 8'hFF) * (b & 8'hFF)) >> 8;
  endfunction

  // Scaling used by the rainbow method: a level that is not zero always stays at least one.
  function automatic int unsigned lift_scale(input int unsigned c, input int unsigned k);
    return (c == 0) ? 0 : ((upper_byte(c, k) + 1) & 8'hFF);
  endfunction

  // Six hue regions of 43 steps each; the last one is shorter and runs up to 255.
  function automatic colour_t generic_colour(input chan_t h, input chan_t s, input chan_t v);
    int unsigned hv, sv, vv, region, rem, p, q, t;
    colour_t     c;
    hv = h;
    sv = s;
    vv = v;
    if (sv == 0) begin
      // Grey passes straight through.
      c.red   = v;
      c.green = v;
      c.blue  = v;
      return c;
    end
    region = hv / 43;
    rem    = (hv - region * 43) * 6;
    p      = (vv * (255 - sv)) >> 8;
    q      = (vv * (255 - ((sv * rem) >> 8))) >> 8;
    t      = (vv * (255 - ((sv * (255 - rem)) >> 8))) >> 8;
    case (region)
      0: begin
        c.red = 8'(vv); c.green = 8'(t);  c.blue = 8'(p);
      end
      1: begin
        c.red = 8'(q);  c.green = 8'(vv); c.blue = 8'(p);
      end
      2: begin
        c.red = 8'(p);  c.green = 8'(vv); c.blue = 8'(t);
      end
      3: begin
        c.red = 8'(p);  c.green = 8'(q);  c.blue = 8'(vv);
      end
      4: begin
        c.red = 8'(t);  c.green = 8'(p);  c.blue = 8'(vv);
      end
      default: begin
        c.red = 8'(vv); c.green = 8'(p);  c.blue = 8'(q);
      end
    endcase
    return c;
  endfunction

  // Eight sections of 32 hue steps, green trimmed to 185/256, then saturation and brightness.
  function automatic colour_t rainbow_colour(input chan_t h, input chan_t s, input chan_t v);
    int unsigned hv, sv, vv, off8, third, two, r, g, b, lack, base, v_sq;
    colour_t     c;
    hv    = h;
    sv    = s;
    vv    = v;
    off8  = (hv & 32'h1F) << 3;
    third = upper_byte(off8, 85);
    two   = upper_byte(off8, 170);
    case ((hv >> 5) & 7)
      0: begin
        r = 255 - third; g = third;       b = 0;
      end
      1: begin
        r = 171;         g = 85 + third;  b = 0;
      end
      2: begin
        r = 171 - two;   g = 170 + third; b = 0;
      end
      3: begin
        r = 0;           g = 255 - third; b = third;
      end
      4: begin
        r = 0;           g = 171 - two;   b = 85 + two;
      end
      5: begin
        r = third;       g = 0;           b = 255 - third;
      end
      6: begin
        r = 85 + third;  g = 0;           b = 171 - third;
      end
      default: begin
        r = 170 + third; g = 0;           b = 85 - third;
      end
    endcase
    g = upper_byte(g, 185);

    if (sv == 0) begin
      // No saturation at all means white before the brightness is applied.
      r = 255;
      g = 255;
      b = 255;
    end else if (sv != 255) begin
      // The desaturation floor is added with a wrap at 256.
      lack = 255 - sv;
      base = upper_byte(lack, lack);
      r    = (lift_scale(r, sv) + base) & 8'hFF;
      g    = (lift_scale(g, sv) + base) & 8'hFF;
      b    = (lift_scale(b, sv) + base) & 8'hFF;
    end

    if (vv != 255) begin
      v_sq = upper_byte(vv, vv);
      if (v_sq == 0) begin
        r = 0;
        g = 0;
        b = 0;
      end else begin
        r = lift_scale(r, v_sq);
        g = lift_scale(g, v_sq);
        b = lift_scale(b, v_sq);
      end
    end
    c.red   = 8'(r);
    c.green = 8'(g);
    c.blue  = 8'(b);
    return c;
  endfunction

  function automatic colour_t predict_colour(input logic mode, input chan_t h, input chan_t s,
                                             input chan_t v);
    return (mode == MODE_RAINBOW) ? rainbow_colour(h, s, v) : generic_colour(h, s, v);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driving the converter
  // ---------------------------------------------------------------------------------------

  // Sends one pixel word. An optional idle stretch comes first; the word is taken at the first
  // rising edge at which start is high and busy is low, and its colour is queued there. When no
  // idle stretch is drawn, start simply stays high from the previous word, so it is never
  // lowered and raised within the same time step.
  task automatic send_pixel(input chan_t h, input chan_t s, input chan_t v);
    int unsigned gap;
    gap = $urandom_range(max_gap, 0);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    hue_angle  <= h;
    saturation <= s;
    brightness <= v;
    do @(posedge clk); while (busy !== 1'b0);
    pending_colours.push_back(predict_colour(active_mode, h, s, v));
  endtask

  // Stops sending, waits for every outstanding colour and then lets the pipeline settle.
  // A colour that never turns up counts as a failure.
  task automatic drain_pipeline();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    while (pending_colours.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_colours.size() != 0) begin
      $error("%0d expected colour words never arrived", pending_colours.size());
      mismatches++;
      pending_colours.delete();
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Writes the mode register once the converter is idle; the predictor follows at acceptance.
  task automatic write_mode(input logic mode);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid   <= 1'b0;
    active_mode  = mode;
  endtask

  // Mostly uniform levels, with the ends of the range and the dark region near zero favoured.
  function automatic chan_t pick_level();
    case ($urandom_range(7, 0))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(16, 1));
      3:       return 8'($urandom_range(255, 240));
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Generic method: both edges of every hue region, grey, and the extremes of each field.
  task automatic test_generic_corners();
    int unsigned k;
    write_mode(MODE_GENERIC);
    max_gap = 4;
    for (k = 0; k < 6; k++) begin
      send_pixel(8'(43 * k), 8'd255, 8'd255);
      // The last region is cut short at the top of the hue circle.
      send_pixel((k < 5) ? 8'(43 * k + 42) : 8'd255, 8'd200, 8'd255);
    end
    send_pixel(8'd77,  8'd0,   8'd200);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd128, 8'd1,   8'd255);
    send_pixel(8'd170, 8'd254, 8'd1);
    send_pixel(8'hAA,  8'h55,  8'hAA);
    send_pixel(8'h55,  8'hAA,  8'h55);
  endtask

  // Rainbow method: both ends of all eight sections, then white, the floor and the dark limit.
  task automatic test_rainbow_corners();
    int unsigned k;
    write_mode(MODE_RAINBOW);
    max_gap = 0;
    for (k = 0; k < 8; k++) begin
      send_pixel(8'(32 * k), 8'd255, 8'd255);
      send_pixel(8'(32 * k + 31), 8'd255, 8'd255);
    end
    max_gap = 4;
    send_pixel(8'd100, 8'd0,   8'd255);
    send_pixel(8'd10,  8'd1,   8'd255);
    send_pixel(8'd200, 8'd2,   8'd200);
    // Brightness 15 squares to nothing and gives black; 16 is the first visible level.
    send_pixel(8'd60,  8'd128, 8'd15);
    send_pixel(8'd60,  8'd128, 8'd16);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd254);
  endtask

  // Random pixels in several phases. The mode changes between phases, sometimes to the value
  // it already holds, and some phases run with no idle cycles at all.
  task automatic test_random_pixels();
    int unsigned phase, n;
    logic        mode;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 2) mode = (phase == 0) ? MODE_GENERIC : MODE_RAINBOW;
      else           mode = ($urandom_range(1, 0) != 0) ? MODE_RAINBOW : MODE_GENERIC;
      write_mode(mode);
      max_gap = (phase % 3 == 1) ? 0 : 4;
      for (n = 0; n < RANDOM_WORDS / RANDOM_PHASES; n++) begin
        send_pixel(pick_level(), pick_level(), pick_level());
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------------------

  task automatic compare_level(input string field, input chan_t want, input chan_t got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  // The result word cannot be held off, so each done strobe is checked at the edge that ends
  // its cycle. Sampling right at the edge sees the values from before it, which keeps the
  // check independent of event order within the time step.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_colours.size() == 0) begin
        $error("unexpected colour word: red %0d, green %0d, blue %0d",
               red_level, green_level, blue_level);
        mismatches++;
      end else begin
        oldest_colour = pending_colours.pop_front();
        compare_level("red_level",   oldest_colour.red,   red_level);
        compare_level("green_level", oldest_colour.green, green_level);
        compare_level("blue_level",  oldest_colour.blue,  blue_level);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Reset is held at the start and never asserted again.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_generic_corners();
    test_rainbow_corners();
    test_random_pixels();
    drain_pipeline();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
